>>> src/qcfl_pkg.sv
// qcfl_pkg: shared constants and types for the curvature / FRAM limiter core.
// No dependencies; used by every module in src.
`timescale 1ns / 1ps

package qcfl_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FACTOR_BITS    = 32;
    localparam int LIM_FRAC       = 16;
    localparam int DIV_STEPS      = LIM_FRAC;
    localparam int LIM_BITS       = LIM_FRAC + 1;
    localparam int MR_BITS        = 16;
    localparam int ADDR_BITS      = 3;
    localparam int DATA_BITS      = 32;

    localparam logic [MR_BITS-1:0]  MIN_RANGE_RST = MR_BITS'(1);
    localparam logic [LIM_BITS-1:0] LIM_ONE       = LIM_BITS'(1) << LIM_FRAC;

    typedef enum logic {
        REG_MIN_RANGE = 1'b0,
        REG_NONE      = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic wall;
        logic small_rng;
        logic one;
    } t_flags;

endpackage

>>> src/qcfl_div_cell.sv
// qcfl_div_cell: one restoring-division cell, one quotient bit per stage.
// Depends on qcfl_pkg.
`timescale 1ns / 1ps

module qcfl_div_cell #(
    parameter int RW = qcfl_pkg::VALUE_BITS_DEF + 1
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [RW-1:0]                 i_rem,
    input  logic [RW-1:0]                 i_range,
    input  logic [qcfl_pkg::LIM_FRAC-1:0] i_q,
    output logic [RW-1:0]                 o_rem,
    output logic [RW-1:0]                 o_range,
    output logic [qcfl_pkg::LIM_FRAC-1:0] o_q
);

    logic [RW:0]                   w_rem2;
    logic                          w_ge;
    logic [RW-1:0]                 n_rem;
    logic [qcfl_pkg::LIM_FRAC-1:0] n_q;
    logic [RW-1:0]                 r_rem;
    logic [RW-1:0]                 r_range;
    logic [qcfl_pkg::LIM_FRAC-1:0] r_q;

    always_comb begin
        w_rem2 = {i_rem, 1'b0};
        w_ge   = w_rem2 >= {1'b0, i_range};
        n_rem  = w_ge ? RW'(w_rem2 - {1'b0, i_range}) : w_rem2[RW-1:0];
        n_q    = {i_q[qcfl_pkg::LIM_FRAC-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_range <= i_range;
            r_q     <= n_q;
        end
    end

    assign o_rem   = r_rem;
    assign o_range = r_range;
    assign o_q     = r_q;

endmodule

>>> src/qcfl_curv.sv
// qcfl_curv: two-stage weighted second difference with floor shift and saturation.
// Depends on qcfl_pkg.
`timescale 1ns / 1ps

module qcfl_curv #(
    parameter int VALUE_BITS = qcfl_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = qcfl_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [VALUE_BITS:0]          i_d_right,
    input  logic signed [VALUE_BITS:0]          i_d_left,
    input  logic [qcfl_pkg::FACTOR_BITS-1:0]    i_right_factor,
    input  logic [qcfl_pkg::FACTOR_BITS-1:0]    i_left_factor,
    output logic [VALUE_BITS-1:0]               o_curv,
    output logic                                o_sat
);

    localparam int PW = VALUE_BITS + qcfl_pkg::FACTOR_BITS + 2;
    localparam int SW = PW + 1;

    logic signed [PW-1:0]         r_pr;
    logic signed [PW-1:0]         r_pl;
    logic signed [SW-1:0]         w_diff;
    logic signed [SW-1:0]         w_sh;
    logic                         w_fit;
    logic [VALUE_BITS-1:0]        n_curv;
    logic [VALUE_BITS-1:0]        r_curv;
    logic                         r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr <= PW'(i_d_right * $signed({1'b0, i_right_factor}));
            r_pl <= PW'(i_d_left * $signed({1'b0, i_left_factor}));
        end
    end

    always_comb begin
        w_diff = $signed({r_pr[PW-1], r_pr}) - $signed({r_pl[PW-1], r_pl});
        w_sh   = w_diff >>> FRAC_BITS;
        w_fit  = (&w_sh[SW-1:VALUE_BITS-1]) || !(|w_sh[SW-1:VALUE_BITS-1]);
        if (w_fit) begin
            n_curv = w_sh[VALUE_BITS-1:0];
        end else if (w_sh[SW-1]) begin
            n_curv = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            n_curv = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_curv <= n_curv;
            r_sat  <= !w_fit;
        end
    end

    assign o_curv = r_curv;
    assign o_sat  = r_sat;

endmodule

>>> src/qcfl_pow4.sv
// qcfl_pow4: fourth power of the Q0.16 quotient with limiter selection, two stages.
// Depends on qcfl_pkg.
`timescale 1ns / 1ps

module qcfl_pow4 (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qcfl_pkg::LIM_FRAC-1:0]  i_q,
    input  qcfl_pkg::t_flags               i_flags,
    output logic [qcfl_pkg::LIM_BITS-1:0]  o_limiter
);

    localparam int QW = 2 * qcfl_pkg::LIM_FRAC;
    localparam int FW = 4 * qcfl_pkg::LIM_FRAC;

    logic [QW-1:0]                  r_q2;
    qcfl_pkg::t_flags               r_flags;
    logic [FW-1:0]                  w_q4;
    logic [qcfl_pkg::LIM_BITS-1:0]  n_lim;
    logic [qcfl_pkg::LIM_BITS-1:0]  r_lim;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q2    <= QW'(i_q * i_q);
            r_flags <= i_flags;
        end
    end

    always_comb begin
        w_q4 = FW'(r_q2 * r_q2);
        if (r_flags.wall) begin
            n_lim = qcfl_pkg::LIM_ONE;
        end else if (r_flags.small_rng) begin
            n_lim = '0;
        end else if (r_flags.one) begin
            n_lim = qcfl_pkg::LIM_ONE;
        end else begin
            n_lim = qcfl_pkg::LIM_BITS'(w_q4[FW-1:FW-qcfl_pkg::LIM_FRAC]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lim <= n_lim;
        end
    end

    assign o_limiter = r_lim;

endmodule

>>> src/quick_curvature_fram_limiter_core.sv
// quick_curvature_fram_limiter_core: top level of the curvature / FRAM limiter pipeline.
// Depends on qcfl_pkg, qcfl_div_cell, qcfl_curv, qcfl_pow4.
//
// Usage: one beat on the input channel (i_valid / o_ready) carries the three cell
// values, the two spacing factors and the wall flag. One beat on the output
// channel (o_valid / i_ready) returns curvature, limiter and saturation flag.
// The pipeline is an operand stage, a row of 16 division cells (one
// quotient bit each) and two squaring stages; the curvature runs alongside.
// Throughput is one beat per cycle unless stalled; the division cell row sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_ready drops; it rises again as soon as the result is taken.
// min_range is written over the APB port at byte address 0, pready is always
// high. Reset empties the pipeline and sets min_range to 1.
`timescale 1ns / 1ps

module quick_curvature_fram_limiter_core #(
    parameter int VALUE_BITS = qcfl_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = qcfl_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qcfl_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [qcfl_pkg::DATA_BITS-1:0]      pwdata,
    output logic [qcfl_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [VALUE_BITS-1:0]        i_left_value,
    input  logic signed [VALUE_BITS-1:0]        i_center_value,
    input  logic signed [VALUE_BITS-1:0]        i_right_value,
    input  logic [qcfl_pkg::FACTOR_BITS-1:0]    i_left_factor,
    input  logic [qcfl_pkg::FACTOR_BITS-1:0]    i_right_factor,
    input  logic                                i_at_wall,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [VALUE_BITS-1:0]        o_curvature,
    output logic [qcfl_pkg::LIM_BITS-1:0]       o_limiter,
    output logic                                o_curvature_saturated
);

    localparam int RW   = VALUE_BITS + 1;
    localparam int NW   = VALUE_BITS + 3;
    localparam int NST  = qcfl_pkg::DIV_STEPS + 3;
    localparam int CDLY = qcfl_pkg::DIV_STEPS - 1;
    localparam int FDLY = qcfl_pkg::DIV_STEPS + 2;
    localparam int LF   = qcfl_pkg::LIM_FRAC;

    logic [qcfl_pkg::MR_BITS-1:0]  r_min_range;
    qcfl_pkg::t_reg_idx            w_idx;
    logic                          w_en;
    logic [NST-1:0]                r_vld;

    // configuration
    assign w_idx  = qcfl_pkg::t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= qcfl_pkg::MIN_RANGE_RST;
        end else if (psel && penable && pwrite && w_idx == qcfl_pkg::REG_MIN_RANGE) begin
            r_min_range <= pwdata[qcfl_pkg::MR_BITS-1:0];
        end
    end

    always_comb begin
        unique case (w_idx)
            qcfl_pkg::REG_MIN_RANGE: begin
                prdata = qcfl_pkg::DATA_BITS'(r_min_range);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // pipeline advance
    assign w_en    = !r_vld[NST-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // operand stage
    logic signed [VALUE_BITS-1:0]  w_min;
    logic signed [VALUE_BITS-1:0]  w_max;
    logic [RW-1:0]                 w_range;
    logic signed [RW-1:0]          w_cmin;
    logic signed [NW-1:0]          w_num;
    logic [NW-1:0]                 w_mag;
    qcfl_pkg::t_flags              n_flags;

    always_comb begin
        w_min   = (i_left_value < i_right_value) ? i_left_value : i_right_value;
        w_max   = (i_left_value < i_right_value) ? i_right_value : i_left_value;
        w_range = RW'($signed({w_max[VALUE_BITS-1], w_max})
                      - $signed({w_min[VALUE_BITS-1], w_min}));
        w_cmin  = $signed({i_center_value[VALUE_BITS-1], i_center_value})
                  - $signed({w_min[VALUE_BITS-1], w_min});
        w_num   = $signed({w_cmin[RW-1], w_cmin, 1'b0}) - $signed({2'b00, w_range});
        w_mag   = w_num[NW-1] ? NW'(-w_num) : w_num;
        n_flags.wall      = i_at_wall;
        n_flags.small_rng = (w_range == '0) || (w_range < RW'(r_min_range));
        n_flags.one       = w_mag >= NW'(w_range);
    end

    logic [RW-1:0]  r_rem0;
    logic [RW-1:0]  r_rng0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem0 <= n_flags.one ? '0 : w_mag[RW-1:0];
            r_rng0 <= w_range;
        end
    end

    // flag shift line
    qcfl_pkg::t_flags r_fl [FDLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl[0] <= n_flags;
            for (int i = 1; i < FDLY; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
        end
    end

    // curvature
    logic signed [VALUE_BITS:0]  r_dr;
    logic signed [VALUE_BITS:0]  r_dl;
    logic [qcfl_pkg::FACTOR_BITS-1:0] r_rf;
    logic [qcfl_pkg::FACTOR_BITS-1:0] r_lf;
    logic [VALUE_BITS-1:0]       w_curv;
    logic                        w_sat;
    logic [VALUE_BITS-1:0]       r_cv  [CDLY];
    logic                        r_cs  [CDLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dr <= $signed({i_right_value[VALUE_BITS-1], i_right_value})
                    - $signed({i_center_value[VALUE_BITS-1], i_center_value});
            r_dl <= $signed({i_center_value[VALUE_BITS-1], i_center_value})
                    - $signed({i_left_value[VALUE_BITS-1], i_left_value});
            r_rf <= i_right_factor;
            r_lf <= i_left_factor;
        end
    end

    qcfl_curv #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_curv (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_d_right      (r_dr),
        .i_d_left       (r_dl),
        .i_right_factor (r_rf),
        .i_left_factor  (r_lf),
        .o_curv         (w_curv),
        .o_sat          (w_sat)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cv[0] <= w_curv;
            r_cs[0] <= w_sat;
            for (int i = 1; i < CDLY; i++) begin
                r_cv[i] <= r_cv[i-1];
                r_cs[i] <= r_cs[i-1];
            end
        end
    end

    // division cell row
    logic [RW-1:0] w_rem [qcfl_pkg::DIV_STEPS+1];
    logic [RW-1:0] w_rng [qcfl_pkg::DIV_STEPS+1];
    logic [LF-1:0] w_q   [qcfl_pkg::DIV_STEPS+1];

    assign w_rem[0] = r_rem0;
    assign w_rng[0] = r_rng0;
    assign w_q[0]   = '0;

    for (genvar g = 0; g < qcfl_pkg::DIV_STEPS; g++) begin : g_cell
        qcfl_div_cell #(
            .RW (RW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_rem   (w_rem[g]),
            .i_range (w_rng[g]),
            .i_q     (w_q[g]),
            .o_rem   (w_rem[g+1]),
            .o_range (w_rng[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    qcfl_pow4 u_pow4 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_q       (w_q[qcfl_pkg::DIV_STEPS]),
        .i_flags   (r_fl[FDLY-2]),
        .o_limiter (o_limiter)
    );

    // output register for curvature
    logic [VALUE_BITS-1:0] r_curv_o;
    logic                  r_sat_o;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_curv_o <= r_fl[FDLY-1].wall ? '0 : r_cv[CDLY-1];
            r_sat_o  <= r_fl[FDLY-1].wall ? 1'b0 : r_cs[CDLY-1];
        end
    end

    assign o_curvature           = r_curv_o;
    assign o_curvature_saturated = r_sat_o;

    // checks
    a_lim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_limiter <= qcfl_pkg::LIM_ONE)
        else $error("limiter above one");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_curvature_saturated) |->
        (o_curvature == {1'b1, {(VALUE_BITS-1){1'b0}}}
         || o_curvature == {1'b0, {(VALUE_BITS-1){1'b1}}}))
        else $error("saturated curvature not at a bound");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_limiter) && $stable(o_curvature)))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pipeline not empty after reset");

endmodule
